// File: rtl/dbsr_pkg.sv
`default_nettype none
package dbsr_pkg;

    // CRC-8 of the door bus: poly 0x07, MSB first, no final xor
    localparam logic [7:0] CRC_INIT   = 8'hF3;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    // frame constants
    localparam logic [7:0] BCAST_MARK = 8'h12;
    localparam logic [3:0] SCAN_LEN   = 4'h2;
    localparam logic [3:0] REQ_LEN    = 4'h1;
    localparam logic [3:0] SCAN_TAG   = 4'h2;
    localparam logic [3:0] SREQ_TAG   = 4'h3;
    localparam logic [7:0] SREQ_FILL  = 8'h10;
    localparam logic [2:0] LEN_SHORT  = 3'd4;
    localparam logic [2:0] LEN_LONG   = 3'd5;

    // register file
    localparam int unsigned        REG_AW           = 5;
    localparam logic [7:0]         RST_SLAVE_ADDR   = 8'd40;
    localparam logic [7:0]         RST_BCAST_ADDR   = 8'd0;
    localparam logic [7:0]         RST_MASTER_ADDR  = 8'd128;
    localparam logic [7:0]         RST_SLAVE_TYPE   = 8'd20;
    localparam logic [7:0]         RST_SCAN_CMD     = 8'd1;
    localparam logic [7:0]         RST_SREQ_CMD     = 8'd32;
    localparam logic [7:0]         RST_SREPLY_CMD   = 8'd41;
    localparam logic [7:0]         RST_DEFAULT_CODE = 8'd16;

    typedef enum logic [2:0] {
        REG_SLAVE_ADDR   = 3'd0,
        REG_BCAST_ADDR   = 3'd1,
        REG_MASTER_ADDR  = 3'd2,
        REG_SLAVE_TYPE   = 3'd3,
        REG_SCAN_CMD     = 3'd4,
        REG_SREQ_CMD     = 3'd5,
        REG_SREPLY_CMD   = 3'd6,
        REG_DEFAULT_CODE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] slave_addr;
        logic [7:0] bcast_addr;
        logic [7:0] master_addr;
        logic [7:0] slave_type;
        logic [7:0] scan_cmd;
        logic [7:0] sreq_cmd;
        logic [7:0] sreply_cmd;
        logic [7:0] default_code;
    } t_cfg;

    // work queued from front to back
    typedef enum logic [1:0] {
        OP_STATUS = 2'd0,
        OP_SCAN   = 2'd1,
        OP_SREQ   = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  cnt;     // reply counter nibble
        logic [7:0]  pend;    // pending command captured for a status reply
        logic [15:0] status;  // broadcast status
    } t_entry;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // door state codes
    localparam logic [2:0] ST_STOPPED = 3'd0;
    localparam logic [2:0] ST_OPEN    = 3'd1;
    localparam logic [2:0] ST_CLOSED  = 3'd2;
    localparam logic [2:0] ST_VENTING = 3'd3;
    localparam logic [2:0] ST_OPENING = 3'd4;
    localparam logic [2:0] ST_CLOSING = 3'd5;
    localparam logic [2:0] ST_ERROR   = 3'd6;
    localparam logic [2:0] ST_OFFLINE = 3'd7;

    // one byte through the CRC
    function automatic logic [7:0] crc8_step(input logic [7:0] c_in, input logic [7:0] d);
        logic [7:0] c;
        c = c_in ^ d;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dbsr_regs.sv
`default_nettype none
module dbsr_regs
    import dbsr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [REG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic [7:0] w_rd;

    assign w_idx  = t_reg_idx'(paddr[REG_AW-1:2]);
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_addr   <= RST_SLAVE_ADDR;
            r_cfg.bcast_addr   <= RST_BCAST_ADDR;
            r_cfg.master_addr  <= RST_MASTER_ADDR;
            r_cfg.slave_type   <= RST_SLAVE_TYPE;
            r_cfg.scan_cmd     <= RST_SCAN_CMD;
            r_cfg.sreq_cmd     <= RST_SREQ_CMD;
            r_cfg.sreply_cmd   <= RST_SREPLY_CMD;
            r_cfg.default_code <= RST_DEFAULT_CODE;
        end else if (w_wr) begin
            case (w_idx)
                REG_SLAVE_ADDR:   r_cfg.slave_addr   <= pwdata[7:0];
                REG_BCAST_ADDR:   r_cfg.bcast_addr   <= pwdata[7:0];
                REG_MASTER_ADDR:  r_cfg.master_addr  <= pwdata[7:0];
                REG_SLAVE_TYPE:   r_cfg.slave_type   <= pwdata[7:0];
                REG_SCAN_CMD:     r_cfg.scan_cmd     <= pwdata[7:0];
                REG_SREQ_CMD:     r_cfg.sreq_cmd     <= pwdata[7:0];
                REG_SREPLY_CMD:   r_cfg.sreply_cmd   <= pwdata[7:0];
                REG_DEFAULT_CODE: r_cfg.default_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_SLAVE_ADDR:   w_rd = r_cfg.slave_addr;
            REG_BCAST_ADDR:   w_rd = r_cfg.bcast_addr;
            REG_MASTER_ADDR:  w_rd = r_cfg.master_addr;
            REG_SLAVE_TYPE:   w_rd = r_cfg.slave_type;
            REG_SCAN_CMD:     w_rd = r_cfg.scan_cmd;
            REG_SREQ_CMD:     w_rd = r_cfg.sreq_cmd;
            REG_SREPLY_CMD:   w_rd = r_cfg.sreply_cmd;
            REG_DEFAULT_CODE: w_rd = r_cfg.default_code;
            default:          w_rd = 8'h00;
        endcase
    end

    assign prdata = {24'h000000, w_rd};

endmodule
`default_nettype wire

// File: rtl/dbsr_queue.sv
`default_nettype none
module dbsr_queue
    import dbsr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_empty,
    output t_entry      o_data
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (Q_AW+1)'(Q_DEPTH)) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

// File: rtl/dbsr_front.sv
`default_nettype none
module dbsr_front
    import dbsr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cfg            i_cfg,
    input  wire logic       i_accept,
    input  wire logic       i_action,
    input  wire logic [2:0] i_frame_length,
    input  wire logic [7:0] i_byte_zero,
    input  wire logic [7:0] i_byte_one,
    input  wire logic [7:0] i_byte_two,
    input  wire logic [7:0] i_byte_three,
    input  wire logic [7:0] i_byte_four,
    input  wire logic [7:0] i_command_code,
    output logic            o_push,
    output t_entry          o_entry
);

    logic [15:0] r_status, n_status;
    logic [7:0]  r_pend, n_pend;
    logic [7:0]  w_crc3, w_crc4;
    logic        w_len4, w_len5, w_crc_ok, w_bcast, w_to_us, w_scan, w_sreq;
    logic [15:0] w_new_status;

    // CRC over the bytes before the check byte
    assign w_crc3 = crc8_step(crc8_step(crc8_step(CRC_INIT, i_byte_zero), i_byte_one),
                              i_byte_two);
    assign w_crc4 = crc8_step(w_crc3, i_byte_three);

    assign w_len4   = (i_frame_length == LEN_SHORT);
    assign w_len5   = (i_frame_length == LEN_LONG);
    assign w_crc_ok = (w_len4 && w_crc3 == i_byte_three) ||
                      (w_len5 && w_crc4 == i_byte_four);

    // classify the frame; broadcast wins over a request
    assign w_new_status = {i_byte_three, i_byte_two};
    assign w_bcast = !i_action && w_crc_ok && w_len5 && i_byte_zero == i_cfg.bcast_addr &&
                     i_byte_one == BCAST_MARK;
    assign w_to_us = !i_action && w_crc_ok && !w_bcast && i_byte_zero == i_cfg.slave_addr;
    assign w_scan  = w_to_us && w_len5 && i_byte_one[3:0] == SCAN_LEN &&
                     i_byte_two == i_cfg.scan_cmd;
    assign w_sreq  = w_to_us && w_len4 && i_byte_one[3:0] == REQ_LEN &&
                     i_byte_two == i_cfg.sreq_cmd;

    // state update and queue word
    always_comb begin
        n_status       = r_status;
        n_pend         = r_pend;
        o_push         = 1'b0;
        o_entry.op     = OP_STATUS;
        o_entry.cnt    = i_byte_one[7:4] + 4'd1;
        o_entry.pend   = r_pend;
        o_entry.status = w_new_status;
        if (i_accept) begin
            if (i_action) begin
                n_pend = i_command_code;
            end else if (w_bcast) begin
                if (w_new_status != r_status) begin
                    n_status = w_new_status;
                    o_push   = 1'b1;
                end
            end else if (w_scan) begin
                o_entry.op = OP_SCAN;
                o_push     = 1'b1;
            end else if (w_sreq) begin
                o_entry.op = OP_SREQ;
                o_push     = 1'b1;
                n_pend     = i_cfg.default_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_pend   <= RST_DEFAULT_CODE;
        end else begin
            r_status <= n_status;
            r_pend   <= n_pend;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dbsr_back.sv
`default_nettype none
module dbsr_back
    import dbsr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    input  wire logic   i_empty,
    input  t_entry      i_entry,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_reply_byte,
    output logic        o_last,
    output logic [15:0] o_door_status,
    output logic [2:0]  o_door_state
);

    logic        r_valid;
    logic [2:0]  r_idx;
    logic        r_kind, r_last;
    logic [7:0]  r_byte;
    logic [15:0] r_status;
    logic [2:0]  r_state;

    logic        w_load, w_last;
    logic [7:0]  w_t1, w_t2, w_t3, w_crc4, w_crc5, w_byte;
    logic [2:0]  w_final;

    function automatic logic [2:0] door_decode(input logic [15:0] s);
        if (s[0])                   return ST_STOPPED;
        else if (s[1])              return ST_OPEN;
        else if (s[7])              return ST_CLOSED;
        else if (s[6:5] == 2'b10)   return ST_VENTING;
        else if (s[6:5] == 2'b11)   return ST_OPENING;
        else if (s[4])              return ST_CLOSING;
        else if (s == '0)           return ST_ERROR;
        else                        return ST_OFFLINE;
    endfunction

    // reply frame for the head word
    always_comb begin
        if (i_entry.op == OP_SREQ) begin
            w_t1    = {i_entry.cnt, SREQ_TAG};
            w_t2    = i_cfg.sreply_cmd;
            w_t3    = i_entry.pend;
            w_final = 3'd5;
        end else begin
            w_t1    = {i_entry.cnt, SCAN_TAG};
            w_t2    = i_cfg.slave_type;
            w_t3    = i_cfg.slave_addr;
            w_final = (i_entry.op == OP_SCAN) ? 3'd4 : 3'd0;
        end
    end

    assign w_crc4 = crc8_step(crc8_step(crc8_step(crc8_step(CRC_INIT, i_cfg.master_addr),
                              w_t1), w_t2), w_t3);
    assign w_crc5 = crc8_step(w_crc4, SREQ_FILL);

    // byte at the current index
    always_comb begin
        case (r_idx)
            3'd0:    w_byte = i_cfg.master_addr;
            3'd1:    w_byte = w_t1;
            3'd2:    w_byte = w_t2;
            3'd3:    w_byte = w_t3;
            3'd4:    w_byte = (i_entry.op == OP_SREQ) ? SREQ_FILL : w_crc4;
            3'd5:    w_byte = w_crc5;
            default: w_byte = 8'h00;
        endcase
    end

    // one result word per cycle whenever the queue is not empty and the output register frees up
    assign w_load = !i_empty && (!r_valid || !i_out_stall);
    assign w_last = (r_idx == w_final);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 3'd0 : r_idx + 3'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_last <= w_last;
            if (i_entry.op == OP_STATUS) begin
                r_kind   <= 1'b1;
                r_byte   <= 8'h00;
                r_status <= i_entry.status;
                r_state  <= door_decode(i_entry.status);
            end else begin
                r_kind   <= 1'b0;
                r_byte   <= w_byte;
                r_status <= '0;
                r_state  <= '0;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_reply_byte  = r_byte;
    assign o_last        = r_last;
    assign o_door_status = r_status;
    assign o_door_state  = r_state;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx <= w_final))
        else $error("byte index past end of reply");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind) |-> r_last)
        else $error("status update not marked last");

    a_pop_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 3'd0))
        else $error("index not rewound after word");

endmodule
`default_nettype wire

// File: rtl/door_bus_slave_responder_core.sv
`default_nettype none
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ------------------------------------------
// in        sink       i_in_valid / o_in_stall    action, frame_length, byte_zero..four, cmd
// out       source     o_out_valid / i_out_stall  kind, reply_byte, last, door_status/state
// cfg       sink       psel/penable/pwrite/pready 8 byte-wide registers at 4*index
//
// An input word is taken while the queue is not full; the front classifies it and queues any work.
// Results leave one per cycle unless the output stalls: a status update is one word, a scan
// reply 5 bytes, a status reply 6; the back end serializes them a byte per cycle from a 4-word queue.
// Synchronous active-low reset sets the registers to defaults and clears state and queue; no clearing pass.
// The input stalls only while the queue is full; output stall holds the output register.
module door_bus_slave_responder_core
    import dbsr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [REG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // input words
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_action,
    input  wire logic [2:0]        i_frame_length,
    input  wire logic [7:0]        i_byte_zero,
    input  wire logic [7:0]        i_byte_one,
    input  wire logic [7:0]        i_byte_two,
    input  wire logic [7:0]        i_byte_three,
    input  wire logic [7:0]        i_byte_four,
    input  wire logic [7:0]        i_command_code,
    // result words
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_kind,
    output logic [7:0]             o_reply_byte,
    output logic                   o_last,
    output logic [15:0]            o_door_status,
    output logic [2:0]             o_door_state
);

    t_cfg   w_cfg;
    t_entry w_push_data, w_head;
    logic   w_push, w_full, w_pop, w_empty, w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    dbsr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dbsr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_accept       (w_accept),
        .i_action       (i_action),
        .i_frame_length (i_frame_length),
        .i_byte_zero    (i_byte_zero),
        .i_byte_one     (i_byte_one),
        .i_byte_two     (i_byte_two),
        .i_byte_three   (i_byte_three),
        .i_byte_four    (i_byte_four),
        .i_command_code (i_command_code),
        .o_push         (w_push),
        .o_entry        (w_push_data)
    );

    dbsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    dbsr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_empty       (w_empty),
        .i_entry       (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_reply_byte  (o_reply_byte),
        .o_last        (o_last),
        .o_door_status (o_door_status),
        .o_door_state  (o_door_state)
    );

endmodule
`default_nettype wire
